// ===== hw/rtl/rtlp_pkg.sv =====
// Shared types, codes and helpers for the longest-prefix route table.
// No dependencies; imported by the route table top level.
package rtlp_pkg;

  // Default number of route slots
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Operation codes of a request
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // One route as held in the table memory
  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [7:0]  port;
    logic [15:0] cost;
  } entry_t;

  // Set bits of a mask: nibble counts, then a short sum of eight
  function automatic logic [5:0] ones_count(input logic [31:0] v);
    logic [5:0] acc;
    logic [2:0] nib;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      nib = 3'(v[4*k]) + 3'(v[4*k+1]) + 3'(v[4*k+2]) + 3'(v[4*k+3]);
      acc = acc + 6'(nib);
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/rtlp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rtlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/route_table_longest_prefix.sv =====
// Ordered IPv4 route table with add, delete and longest-prefix lookup.
// Depends on rtlp_pkg and on rtlp_ram for the route storage.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   request  | in_valid_i/in_stall_o | operation, prefix, mask, hop, port,
//            |                       | cost, lookup_addr
//   result   | out_valid_o/out_stall_i | status, gateway, port, cost, prefix_len
//
// Add and unknown codes pass straight to the done state, which loads the result
// into the output register. Lookup and delete scan the table first: the scan
// reads one route a cycle through the single RAM read port; a delete writes each
// later route back one slot up. One request is in work at a time; the next one
// is taken the cycle after the result is loaded, and the sequencer holds while
// the output register still carries a stalled result. Reset empties the table.
module route_table_longest_prefix #(
  parameter int unsigned TABLE_DEPTH = rtlp_pkg::DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] net_prefix_i,
  input  logic [31:0] net_mask_i,
  input  logic [31:0] next_hop_i,
  input  logic        has_next_hop_i,
  input  logic [7:0]  egress_port_i,
  input  logic [15:0] route_cost_i,
  input  logic [31:0] lookup_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] hit_gateway_o,
  output logic [7:0]  hit_port_o,
  output logic [15:0] hit_cost_o,
  output logic [5:0]  hit_prefix_len_o
);
  import rtlp_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $bits(entry_t);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] iss_q, iss_d;
  logic [CW-1:0] ret_idx_q, ret_idx_d;
  logic          rv_q, rv_d;
  logic          is_del_q, is_del_d;
  logic [31:0]   key_q, key_d;
  logic [31:0]   mask_q, mask_d;
  logic          found_q, found_d;
  logic [5:0]    win_len_q, win_len_d;
  logic [31:0]   best_gw_q, best_gw_d;
  logic [7:0]    best_port_q, best_port_d;
  logic [15:0]   best_cost_q, best_cost_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [31:0]   out_gw_q, out_gw_d;
  logic [7:0]    out_port_q, out_port_d;
  logic [15:0]   out_cost_q, out_cost_d;
  logic [5:0]    out_len_q, out_len_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd_entry;
  logic [EW-1:0] ram_rdata;

  logic          in_take, out_free, issue, scan_end;
  logic          lk_hit, del_hit;
  logic [5:0]    e_len;
  logic [CW-1:0] prev_idx;
  entry_t        add_entry;

  // Route storage
  rtlp_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and scan control
  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign issue      = (state_q == S_SCAN) && (iss_q < count_q);
  assign scan_end   = (state_q == S_SCAN) && !rv_q && (iss_q == count_q);
  assign ram_re     = issue;
  assign ram_raddr  = iss_q[AW-1:0];
  assign prev_idx   = ret_idx_q - CW'(1);

  // Compare of the route returned by the memory
  assign rd_entry = entry_t'(ram_rdata);
  assign e_len    = ones_count(rd_entry.mask);
  assign lk_hit   = ((key_q & rd_entry.mask) == rd_entry.network);
  assign del_hit  = (rd_entry.network == key_q) && (rd_entry.mask == mask_q);

  // Route built from an add request
  always_comb begin
    add_entry.network = net_prefix_i;
    add_entry.mask    = net_mask_i;
    add_entry.gateway = has_next_hop_i ? next_hop_i : 32'd0;
    add_entry.port    = egress_port_i;
    add_entry.cost    = route_cost_i;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i inside {OP_DELETE, OP_LOOKUP}) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory accesses
  always_comb begin
    count_d      = count_q;
    iss_d        = iss_q;
    ret_idx_d    = ret_idx_q;
    rv_d         = rv_q;
    is_del_d     = is_del_q;
    key_d        = key_q;
    mask_d       = mask_q;
    found_d      = found_q;
    win_len_d    = win_len_q;
    best_gw_d    = best_gw_q;
    best_port_d  = best_port_q;
    best_cost_d  = best_cost_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_gw_d     = out_gw_q;
    out_port_d   = out_port_q;
    out_cost_d   = out_cost_q;
    out_len_d    = out_len_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = add_entry;

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          is_del_d     = (operation_i == OP_DELETE);
          key_d        = (operation_i == OP_DELETE) ? net_prefix_i : lookup_addr_i;
          mask_d       = net_mask_i;
          iss_d        = '0;
          rv_d         = 1'b0;
          found_d      = 1'b0;
          win_len_d    = '0;
          best_gw_d    = '0;
          best_port_d  = '0;
          best_cost_d  = '0;
          res_status_d = STATUS_MISS;
          // Add completes here: append at the fill count
          if (operation_i == OP_ADD) begin
            if (count_q >= DEPTH_C) begin
              res_status_d = STATUS_FULL;
            end else begin
              ram_we       = 1'b1;
              ram_waddr    = count_q[AW-1:0];
              count_d      = count_q + CW'(1);
              res_status_d = STATUS_OK;
            end
          end
        end
      end
      S_SCAN: begin
        // issue the next read
        rv_d = issue;
        if (issue) begin
          iss_d     = iss_q + CW'(1);
          ret_idx_d = iss_q;
        end
        // evaluate the route read last cycle
        if (rv_q) begin
          if (is_del_q) begin
            if (found_q) begin
              // close the gap: move this route one slot up
              ram_we    = 1'b1;
              ram_waddr = prev_idx[AW-1:0];
              ram_wdata = rd_entry;
            end else if (del_hit) begin
              found_d = 1'b1;
            end
          end else if (lk_hit && (!found_q || e_len > win_len_q)) begin
            found_d     = 1'b1;
            win_len_d   = e_len;
            best_gw_d   = rd_entry.gateway;
            best_port_d = rd_entry.port;
            best_cost_d = rd_entry.cost;
          end
        end
        if (scan_end) begin
          res_status_d = found_q ? STATUS_OK : STATUS_MISS;
          if (is_del_q && found_q) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_gw_d     = best_gw_q;
          out_port_d   = best_port_q;
          out_cost_d   = best_cost_q;
          out_len_d    = win_len_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rv_q        <= rv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    iss_q        <= iss_d;
    ret_idx_q    <= ret_idx_d;
    is_del_q     <= is_del_d;
    key_q        <= key_d;
    mask_q       <= mask_d;
    win_len_q    <= win_len_d;
    best_gw_q    <= best_gw_d;
    best_port_q  <= best_port_d;
    best_cost_q  <= best_cost_d;
    res_status_q <= res_status_d;
    out_status_q <= out_status_d;
    out_gw_q     <= out_gw_d;
    out_port_q   <= out_port_d;
    out_cost_q   <= out_cost_d;
    out_len_q    <= out_len_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign hit_gateway_o    = out_gw_q;
  assign hit_port_o       = out_port_q;
  assign hit_cost_o       = out_cost_q;
  assign hit_prefix_len_o = out_len_q;

`ifndef SYNTH
  // fill count never passes the table size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("route count beyond table depth");

  // a write during the scan only ever moves routes of a matched delete
  a_scan_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == S_SCAN) |-> (is_del_q && found_q))
    else $error("unexpected table write during scan");

  // the shift writes strictly below the slot being read
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr < ram_raddr))
    else $error("read and write collide on one slot");

  // a result only appears after the sequencer has finished a request
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside the done state");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the longest-prefix route table: directed and random requests,
// predicted results checked in order. Depends on rtlp_pkg and route_table_longest_prefix.
module tb_top;
  import rtlp_pkg::*;

  localparam int unsigned SLOTS        = DEPTH_DEFAULT;
  localparam int          RANDOM_REQS  = 1700;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 40;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  // One request and one result as the bench sees them
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] hop;
    logic        has_hop;
    logic [7:0]  port;
    logic [15:0] cost;
    logic [31:0] dest;
  } route_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] gateway;
    logic [7:0]  port;
    logic [15:0] cost;
    logic [5:0]  plen;
  } route_rsp_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i    = '0;
  logic [31:0] net_prefix_i   = '0;
  logic [31:0] net_mask_i     = '0;
  logic [31:0] next_hop_i     = '0;
  logic        has_next_hop_i = 1'b0;
  logic [7:0]  egress_port_i  = '0;
  logic [15:0] route_cost_i   = '0;
  logic [31:0] lookup_addr_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] hit_gateway_o;
  logic [7:0]  hit_port_o;
  logic [15:0] hit_cost_o;
  logic [5:0]  hit_prefix_len_o;

  route_table_longest_prefix #(
    .TABLE_DEPTH(SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .net_prefix_i    (net_prefix_i),
    .net_mask_i      (net_mask_i),
    .next_hop_i      (next_hop_i),
    .has_next_hop_i  (has_next_hop_i),
    .egress_port_i   (egress_port_i),
    .route_cost_i    (route_cost_i),
    .lookup_addr_i   (lookup_addr_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .hit_gateway_o   (hit_gateway_o),
    .hit_port_o      (hit_port_o),
    .hit_cost_o      (hit_cost_o),
    .hit_prefix_len_o(hit_prefix_len_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  route_req_t  pending_q[$];
  route_rsp_t  route_results_q[$];
  int          reqs_total   = 0;
  int          reqs_taken   = 0;
  int          results_seen = 0;
  int          mismatch_cnt = 0;
  int          quiet_cycles = 0;

  // Shadow route table used for prediction
  logic [31:0] tbl_net  [SLOTS];
  logic [31:0] tbl_mask [SLOTS];
  logic [31:0] tbl_gw   [SLOTS];
  logic [7:0]  tbl_port [SLOTS];
  logic [15:0] tbl_cost [SLOTS];
  int unsigned tbl_count = 0;

  // Keys the generator believes are live, to aim deletes and lookups
  logic [31:0] gen_net[$];
  logic [31:0] gen_mask[$];

  // Idle percentages: sender light / receiver heavy, then swapped, then none
  function automatic int idle_pct(input bit receiver);
    int phase;
    phase = (reqs_total == 0) ? 0 : (reqs_taken * 3) / reqs_total;
    case (phase)
      0:       return receiver ? 50 : 7;
      1:       return receiver ? 7 : 50;
      default: return 0;
    endcase
  endfunction

  // Applies one request to the shadow table and returns the result it gives
  function automatic route_rsp_t route_table_apply(input route_req_t r);
    route_rsp_t  res;
    bit          found;
    int unsigned best;
    int unsigned top_len;
    int unsigned len;
    int unsigned k;
    int unsigned j;
    res        = '0;
    res.status = STATUS_MISS;
    found      = 1'b0;
    best       = 0;
    top_len    = 0;
    case (r.op)
      OP_ADD: begin
        if (tbl_count >= SLOTS) begin
          res.status = STATUS_FULL;
        end else begin
          tbl_net[tbl_count]  = r.prefix;
          tbl_mask[tbl_count] = r.mask;
          tbl_gw[tbl_count]   = r.has_hop ? r.hop : 32'h0;
          tbl_port[tbl_count] = r.port;
          tbl_cost[tbl_count] = r.cost;
          tbl_count++;
          res.status = STATUS_OK;
        end
      end
      OP_DELETE: begin
        // first exact match goes, later routes move up one place
        for (k = 0; k < tbl_count && !found; k++) begin
          if (tbl_net[k] == r.prefix && tbl_mask[k] == r.mask) begin
            for (j = k; j + 1 < tbl_count; j++) begin
              tbl_net[j]  = tbl_net[j+1];
              tbl_mask[j] = tbl_mask[j+1];
              tbl_gw[j]   = tbl_gw[j+1];
              tbl_port[j] = tbl_port[j+1];
              tbl_cost[j] = tbl_cost[j+1];
            end
            tbl_count--;
            found      = 1'b1;
            res.status = STATUS_OK;
          end
        end
      end
      OP_LOOKUP: begin
        // most set mask bits wins, earliest route on a tie
        for (k = 0; k < tbl_count; k++) begin
          len = $countones(tbl_mask[k]);
          if ((r.dest & tbl_mask[k]) == tbl_net[k] && (!found || len > top_len)) begin
            found   = 1'b1;
            best    = k;
            top_len = len;
          end
        end
        if (found) begin
          res.status  = STATUS_OK;
          res.gateway = tbl_gw[best];
          res.port    = tbl_port[best];
          res.cost    = tbl_cost[best];
          res.plen    = 6'(top_len);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    $display("result %0d: %s got %h want %h", results_seen, what, got, want);
  endtask

  task automatic push_req(input logic [1:0] op, input logic [31:0] prefix,
                          input logic [31:0] mask, input logic [31:0] hop,
                          input logic has_hop, input logic [7:0] port,
                          input logic [15:0] cost, input logic [31:0] dest);
    pending_q.push_back('{op, prefix, mask, hop, has_hop, port, cost, dest});
  endtask

  // Request driver: predicts on acceptance, then presents the next request
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    route_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        route_results_q.push_back(route_table_apply('{operation_i, net_prefix_i, net_mask_i,
            next_hop_i, has_next_hop_i, egress_port_i, route_cost_i, lookup_addr_i}));
        reqs_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          nxt            = pending_q.pop_front();
          operation_i    <= nxt.op;
          net_prefix_i   <= nxt.prefix;
          net_mask_i     <= nxt.mask;
          next_hop_i     <= nxt.hop;
          has_next_hop_i <= nxt.has_hop;
          egress_port_i  <= nxt.port;
          route_cost_i   <= nxt.cost;
          lookup_addr_i  <= nxt.dest;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks against the oldest prediction, stalls at random
  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    route_rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (route_results_q.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(status_o), 32'h0);
        end else begin
          want = route_results_q.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (hit_gateway_o !== want.gateway)
            report_mismatch("hit_gateway", hit_gateway_o, want.gateway);
          if (hit_port_o !== want.port)
            report_mismatch("hit_port", 32'(hit_port_o), 32'(want.port));
          if (hit_cost_o !== want.cost)
            report_mismatch("hit_cost", 32'(hit_cost_o), 32'(want.cost));
          if (hit_prefix_len_o !== want.plen)
            report_mismatch("hit_prefix_len", 32'(hit_prefix_len_o), 32'(want.plen));
        end
        results_seen++;
      end
      out_stall_i <= ($urandom_range(0, 99) < idle_pct(1'b1));
    end
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    route_req_t rq;
    int         n;
    int         k;
    int         roll;
    int         plen;
    bit         filling;
    filling = 1'b1;

    // directed: empty table, field extremes, gateway-less add, ties, deletes
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0);
    push_req(OP_DELETE,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0);
    push_req(OP_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF,
             16'hFFFF, 32'hFFFF_FFFF);
    push_req(OP_ADD,     32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 8'hFF, 16'hFFFF, 32'h0);
    push_req(OP_ADD,     32'h0A00_0000, 32'hFF00_0000, 32'h1234_5678, 1'b0, 8'h0,
             16'h0, 32'h0);
    push_req(OP_ADD,     32'h0A01_0000, 32'hFFFF_0000, 32'h0A00_0001, 1'b1, 8'h1,
             16'd10, 32'h0);
    push_req(OP_ADD,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 8'h7, 16'h1, 32'h0);
    push_req(OP_ADD,     32'h0001_000B, 32'h00FF_00FF, 32'hC0A8_0001, 1'b1, 8'h3,
             16'h3, 32'h0);
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0A01_0A0B);
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0A7F_0000);
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'hFFFF_FFFF);
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'hC0A8_0001);
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0B01_000B);
    push_req(OP_DELETE,  32'h0A01_0000, 32'hFFFF_0000, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0);
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0A01_0A0B);
    push_req(OP_DELETE,  32'h0A00_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0);
    push_req(OP_ADD,     32'h0A00_0000, 32'hFF00_0000, 32'hC000_0001, 1'b1, 8'h2,
             16'h2, 32'h0);
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0A00_0001);
    push_req(OP_DELETE,  32'h0A00_0000, 32'hFF00_0000, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0);
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0A00_0001);
    push_req(OP_ADD,     32'h0A0A_0A0A, 32'hFF00_0000, 32'h5555_AAAA, 1'b1, 8'h5A,
             16'hA5A5, 32'h0);
    push_req(OP_LOOKUP,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0A0A_0A0A);
    push_req(OP_UNUSED,  32'h0, 32'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0A00_0001);

    // generator's view of the table after the directed part
    gen_net  = '{32'h0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_000B, 32'h0A00_0000,
                 32'h0A0A_0A0A};
    gen_mask = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'hFF00_0000, 32'hFF00_0000};
    void'(gen_net.pop_front());
    void'(gen_mask.pop_front());

    // random: bursts that fill or drain the table, the kind picked at random
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 60 == 0)
        filling = $urandom_range(0, 1);
      rq.op      = OP_LOOKUP;
      rq.prefix  = $urandom;
      rq.mask    = $urandom;
      rq.hop     = $urandom;
      rq.has_hop = $urandom_range(0, 1);
      rq.port    = $urandom_range(0, 255);
      rq.cost    = $urandom_range(0, 65535);
      rq.dest    = $urandom;
      roll       = $urandom_range(0, 99);
      if (roll < (filling ? 55 : 20)) begin
        rq.op = OP_ADD;
        k     = $urandom_range(0, 9);
        if (k < 7) begin
          plen    = $urandom_range(0, 32);
          rq.mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
        end
        if (k == 9 && gen_net.size() > 0) begin
          // duplicate key, so delete order and tie order matter
          k         = $urandom_range(0, gen_net.size() - 1);
          rq.prefix = gen_net[k];
          rq.mask   = gen_mask[k];
        end else if ($urandom_range(0, 9) != 0) begin
          rq.prefix = rq.prefix & rq.mask;
        end
        if (gen_net.size() < SLOTS) begin
          gen_net.push_back(rq.prefix);
          gen_mask.push_back(rq.mask);
        end
      end else if (roll < (filling ? 70 : 60)) begin
        rq.op = OP_DELETE;
        if (gen_net.size() > 0 && $urandom_range(0, 4) != 0) begin
          k         = $urandom_range(0, gen_net.size() - 1);
          rq.prefix = gen_net[k];
          rq.mask   = gen_mask[k];
        end
        for (k = 0; k < gen_net.size(); k++) begin
          if (gen_net[k] == rq.prefix && gen_mask[k] == rq.mask) begin
            gen_net.delete(k);
            gen_mask.delete(k);
            break;
          end
        end
      end else if (roll < 96) begin
        // mostly addresses inside a live route, host bits random
        if (gen_net.size() > 0 && $urandom_range(0, 3) != 0) begin
          k       = $urandom_range(0, gen_net.size() - 1);
          rq.dest = (gen_net[k] & gen_mask[k]) | (rq.dest & ~gen_mask[k]);
        end
      end else begin
        rq.op = OP_UNUSED;
      end
      pending_q.push_back(rq);
    end
    reqs_total = pending_q.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // drain: all requests taken, all results back, then a short tail
    while (pending_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    while (route_results_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rtlp_pkg.sv
hw/rtl/rtlp_ram.sv
hw/rtl/route_table_longest_prefix.sv
sim/tb_top.sv
